/* rtl/hsv2rgb_pkg.sv */
// Package for the HSV to RGB converter: request and response types, constants, fraction table.
package hsv2rgb_pkg;

   localparam int unsigned SECTOR_DEGREES = 60;
   localparam int unsigned FULL_SCALE     = 255;
   localparam int unsigned PRODUCT_SHIFT  = 8;
   localparam int unsigned SECTOR_COUNT   = 9;

   localparam int unsigned HUE_WIDTH    = 9;
   localparam int unsigned CHAN_WIDTH   = 8;
   localparam int unsigned SECTOR_WIDTH = 4;
   localparam int unsigned REM_WIDTH    = 6;

   // Colour-wheel sectors; sector five and all higher ones share one arm
   localparam logic [SECTOR_WIDTH-1:0] SECTOR_RED_YELLOW    = 4'd0;
   localparam logic [SECTOR_WIDTH-1:0] SECTOR_YELLOW_GREEN  = 4'd1;
   localparam logic [SECTOR_WIDTH-1:0] SECTOR_GREEN_CYAN    = 4'd2;
   localparam logic [SECTOR_WIDTH-1:0] SECTOR_CYAN_BLUE     = 4'd3;
   localparam logic [SECTOR_WIDTH-1:0] SECTOR_BLUE_MAGENTA  = 4'd4;

   typedef struct packed {
      logic [HUE_WIDTH-1:0]  hue;
      logic [CHAN_WIDTH-1:0] saturation;
      logic [CHAN_WIDTH-1:0] brightness;
   } req_type;

   typedef struct packed {
      logic [CHAN_WIDTH-1:0] red;
      logic [CHAN_WIDTH-1:0] green;
      logic [CHAN_WIDTH-1:0] blue;
   } rsp_type;

   typedef logic [CHAN_WIDTH-1:0] frac_table_type [0:SECTOR_DEGREES-1];

   // Fraction within a sector, scaled to full scale and truncated
   function automatic frac_table_type build_frac_table();
      frac_table_type tab;
      for (int i = 0; i < int'(SECTOR_DEGREES); i++) begin
         tab[i] = CHAN_WIDTH'((i * FULL_SCALE) / SECTOR_DEGREES);
      end
      return tab;
   endfunction

   localparam frac_table_type FRAC_TABLE = build_frac_table();

endpackage

/* rtl/hsv_to_rgb_converter.sv */
// HSV to RGB converter: five-stage pipeline from hue, saturation and value to 8-bit RGB.
//
// One request is taken in every clock cycle (busy never rises) and its colour appears on
// rsp_data with rsp_strobe high, for one cycle only, after it has passed the five
// register stages (sector split, fraction lookup and p term, saturation products, q and t
// terms, channel select). The receiver cannot stall, so each response must
// be captured in the cycle its strobe is high. Zero saturation gives grey at the value level;
// hues above 359 keep their sector and fraction and use the last sector's channel order.
module hsv_to_rgb_converter (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  hsv2rgb_pkg::req_type  req_data,
   output logic                  rsp_strobe,
   output hsv2rgb_pkg::rsp_type  rsp_data
);

   localparam int unsigned CW = hsv2rgb_pkg::CHAN_WIDTH;
   localparam int unsigned SW = hsv2rgb_pkg::SECTOR_WIDTH;
   localparam int unsigned RW = hsv2rgb_pkg::REM_WIDTH;
   localparam int unsigned HW = hsv2rgb_pkg::HUE_WIDTH;
   localparam logic [CW-1:0] FULL = CW'(hsv2rgb_pkg::FULL_SCALE);

   // Stage 1 registers
   logic          valid1_ff;
   logic [SW-1:0] sector1_ff, sector1_in;
   logic [RW-1:0] rem1_ff, rem1_in;
   logic [CW-1:0] sat1_ff, val1_ff;
   logic          grey1_ff;
   // Stage 2 registers
   logic          valid2_ff;
   logic [SW-1:0] sector2_ff;
   logic [CW-1:0] frac2_ff, sat2_ff, val2_ff, p2_ff;
   logic [2*CW-1:0] p2_in;
   logic          grey2_ff;
   // Stage 3 registers
   logic          valid3_ff;
   logic [SW-1:0] sector3_ff;
   logic [CW-1:0] sf3_ff, sg3_ff, val3_ff, p3_ff;
   logic [2*CW-1:0] sf3_in, sg3_in;
   logic          grey3_ff;
   // Stage 4 registers
   logic          valid4_ff;
   logic [SW-1:0] sector4_ff;
   logic [CW-1:0] q4_ff, t4_ff, val4_ff, p4_ff;
   logic [2*CW-1:0] q4_in, t4_in;
   logic          grey4_ff;
   // Stage 5 registers
   logic          valid5_ff;
   hsv2rgb_pkg::rsp_type rsp_ff, rsp_in;

   // Never stall: every stage advances each cycle
   assign busy = 1'b0;

   // Split the hue into sector and remainder by threshold compares
   always_comb begin
      logic [HW-1:0] base;
      sector1_in = '0;
      for (int k = 1; k < int'(hsv2rgb_pkg::SECTOR_COUNT); k++) begin
         if (req_data.hue >= HW'(k * hsv2rgb_pkg::SECTOR_DEGREES)) begin
            sector1_in = SW'(k);
         end
      end
      base    = HW'(sector1_in) * HW'(hsv2rgb_pkg::SECTOR_DEGREES);
      rem1_in = RW'(req_data.hue - base);
   end

   // Form the saturation-only term p
   assign p2_in = val1_ff * (FULL - sat1_ff);

   // Scale saturation by the fraction and by its complement
   assign sf3_in = sat2_ff * frac2_ff;
   assign sg3_in = sat2_ff * (FULL - frac2_ff);

   // Form the falling and rising terms q and t
   assign q4_in = val3_ff * (FULL - sf3_ff);
   assign t4_in = val3_ff * (FULL - sg3_ff);

   // Route v, p, q and t to the channels by sector
   always_comb begin
      if (grey4_ff) begin
         rsp_in = '{red: val4_ff, green: val4_ff, blue: val4_ff};
      end else begin
         case (sector4_ff)
            hsv2rgb_pkg::SECTOR_RED_YELLOW:   rsp_in = '{red: val4_ff, green: t4_ff,   blue: p4_ff};
            hsv2rgb_pkg::SECTOR_YELLOW_GREEN: rsp_in = '{red: q4_ff,   green: val4_ff, blue: p4_ff};
            hsv2rgb_pkg::SECTOR_GREEN_CYAN:   rsp_in = '{red: p4_ff,   green: val4_ff, blue: t4_ff};
            hsv2rgb_pkg::SECTOR_CYAN_BLUE:    rsp_in = '{red: p4_ff,   green: q4_ff,   blue: val4_ff};
            hsv2rgb_pkg::SECTOR_BLUE_MAGENTA: rsp_in = '{red: t4_ff,   green: p4_ff,   blue: val4_ff};
            default:                          rsp_in = '{red: val4_ff, green: p4_ff,   blue: q4_ff};
         endcase
      end
   end

   // Advance valid bits; clear them on reset
   always_ff @(posedge clock) begin
      if (reset) begin
         valid1_ff <= 1'b0;
         valid2_ff <= 1'b0;
         valid3_ff <= 1'b0;
         valid4_ff <= 1'b0;
         valid5_ff <= 1'b0;
      end else begin
         valid1_ff <= start;
         valid2_ff <= valid1_ff;
         valid3_ff <= valid2_ff;
         valid4_ff <= valid3_ff;
         valid5_ff <= valid4_ff;
      end
   end

   // Advance the payload through the stages
   always_ff @(posedge clock) begin
      sector1_ff <= sector1_in;
      rem1_ff    <= rem1_in;
      sat1_ff    <= req_data.saturation;
      val1_ff    <= req_data.brightness;
      grey1_ff   <= (req_data.saturation == '0);

      sector2_ff <= sector1_ff;
      frac2_ff   <= hsv2rgb_pkg::FRAC_TABLE[rem1_ff];
      sat2_ff    <= sat1_ff;
      val2_ff    <= val1_ff;
      p2_ff      <= p2_in[2*CW-1:CW];
      grey2_ff   <= grey1_ff;

      sector3_ff <= sector2_ff;
      sf3_ff     <= sf3_in[2*CW-1:CW];
      sg3_ff     <= sg3_in[2*CW-1:CW];
      val3_ff    <= val2_ff;
      p3_ff      <= p2_ff;
      grey3_ff   <= grey2_ff;

      sector4_ff <= sector3_ff;
      q4_ff      <= q4_in[2*CW-1:CW];
      t4_ff      <= t4_in[2*CW-1:CW];
      val4_ff    <= val3_ff;
      p4_ff      <= p3_ff;
      grey4_ff   <= grey3_ff;

      rsp_ff     <= rsp_in;
   end

   assign rsp_strobe = valid5_ff;
   assign rsp_data   = rsp_ff;

endmodule
